>>> src/scbp_pkg.sv
// ----------------------------------------------------------------------------
// scbp_pkg: shared types and constants of the size class buffer pool
// Field widths, status and function codes, register indexes, reset values
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package scbp_pkg;

    // Field widths
    localparam int LEN_W      = 16;  // class length and request size
    localparam int SPC_W      = 10;  // class spacing
    localparam int OFS_W      = 10;  // pool offsets on the ports
    localparam int POS_W      = 17;  // running slot start, holds POOL_BYTES
    localparam int SLOT_IDX_W = 5;   // slot index on the ports
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default sizing
    localparam int DEF_CLASS1_SLOTS = 3;
    localparam int DEF_CLASS2_SLOTS = 3;
    localparam int DEF_CLASS3_SLOTS = 3;
    localparam int DEF_CLASS4_SLOTS = 3;
    localparam int DEF_POOL_BYTES   = 1024;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_CLASS1_LEN = 16'd12;
    localparam logic [LEN_W-1:0] RST_CLASS2_LEN = 16'd25;
    localparam logic [LEN_W-1:0] RST_CLASS3_LEN = 16'd55;
    localparam logic [LEN_W-1:0] RST_CLASS4_LEN = 16'd100;
    localparam logic [SPC_W-1:0] RST_CLASS1_SPC = 10'd12;
    localparam logic [SPC_W-1:0] RST_CLASS2_SPC = 10'd25;
    localparam logic [SPC_W-1:0] RST_CLASS3_SPC = 10'd55;
    localparam logic [SPC_W-1:0] RST_CLASS4_SPC = 10'd100;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_NO_CLASS = 3'd1,
        ST_NO_FREE  = 3'd2,
        ST_FREED    = 3'd3,
        ST_UNKNOWN  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLASS1_LEN = 3'd0,
        CFG_CLASS2_LEN = 3'd1,
        CFG_CLASS3_LEN = 3'd2,
        CFG_CLASS4_LEN = 3'd3,
        CFG_CLASS1_SPC = 3'd4,
        CFG_CLASS2_SPC = 3'd5,
        CFG_CLASS3_SPC = 3'd6,
        CFG_CLASS4_SPC = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture request, restart the slot walk
        logic step;    // evaluate current slot, advance
        logic finish;  // latch result, update free map
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // hit on this slot or no slot left
    } t_dp_sts;

endpackage

>>> src/size_class_buffer_pool_core.sv
// ----------------------------------------------------------------------------
// size_class_buffer_pool_core: buffer slot allocator with four size classes
// Sequence: start is taken, then the datapath walks the slots in order until
//   the grant or match or the last slot, then the result strobe is raised.
// A new start is taken in the strobe cycle, but not during the walk (busy).
// Results cannot be stalled by the receiver.
// Reset (synchronous, active low): every slot free, configuration registers to defaults.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_core #(
    parameter int CLASS1_SLOTS = scbp_pkg::DEF_CLASS1_SLOTS,
    parameter int CLASS2_SLOTS = scbp_pkg::DEF_CLASS2_SLOTS,
    parameter int CLASS3_SLOTS = scbp_pkg::DEF_CLASS3_SLOTS,
    parameter int CLASS4_SLOTS = scbp_pkg::DEF_CLASS4_SLOTS,
    parameter int POOL_BYTES   = scbp_pkg::DEF_POOL_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [scbp_pkg::LEN_W-1:0]        i_request_size,
    input  logic [scbp_pkg::OFS_W-1:0]        i_release_offset,
    // Result
    output logic                              o_result_valid,
    output logic [2:0]                        o_status,
    output logic [scbp_pkg::OFS_W-1:0]        o_grant_offset,
    output logic [scbp_pkg::SLOT_IDX_W-1:0]   o_slot_index,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scbp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    scbp_pkg::t_dp_cmd cmd;
    scbp_pkg::t_dp_sts sts;

    // Registers always take a transfer
    assign o_cfg_ready = 1'b1;

    scbp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    scbp_dpath #(
        .CLASS1_SLOTS (CLASS1_SLOTS),
        .CLASS2_SLOTS (CLASS2_SLOTS),
        .CLASS3_SLOTS (CLASS3_SLOTS),
        .CLASS4_SLOTS (CLASS4_SLOTS),
        .POOL_BYTES   (POOL_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_request_size   (i_request_size),
        .i_release_offset (i_release_offset),
        .o_status         (o_status),
        .o_grant_offset   (o_grant_offset),
        .o_slot_index     (o_slot_index)
    );

endmodule

>>> src/scbp_ctrl.sv
// ----------------------------------------------------------------------------
// scbp_ctrl: request sequencer
// Walks a request through capture, slot scan and a one-cycle result strobe.
// ----------------------------------------------------------------------------
module scbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_result_valid,
    output scbp_pkg::t_dp_cmd o_cmd,
    input  scbp_pkg::t_dp_sts i_sts
);

    scbp_pkg::t_state r_state;
    scbp_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state; a new request may start during the result strobe
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scbp_pkg::S_IDLE: begin
                if (start) n_state = scbp_pkg::S_SCAN;
            end
            scbp_pkg::S_SCAN: begin
                if (i_sts.scan_done) n_state = scbp_pkg::S_RESP;
            end
            scbp_pkg::S_RESP: begin
                n_state = start ? scbp_pkg::S_SCAN : scbp_pkg::S_IDLE;
            end
            default: n_state = scbp_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy           = (r_state == scbp_pkg::S_SCAN);
        o_result_valid = (r_state == scbp_pkg::S_RESP);
        o_cmd.load     = start && (r_state != scbp_pkg::S_SCAN);
        o_cmd.step     = (r_state == scbp_pkg::S_SCAN);
        o_cmd.finish   = (r_state == scbp_pkg::S_SCAN) && i_sts.scan_done;
    end

endmodule

>>> src/scbp_dpath.sv
// ----------------------------------------------------------------------------
// scbp_dpath: slot walker, free map and configuration registers
// One slot per cycle: running start offset, class select, fit/free/match
// checks, and the result registers.
// ----------------------------------------------------------------------------
module scbp_dpath #(
    parameter int CLASS1_SLOTS = scbp_pkg::DEF_CLASS1_SLOTS,
    parameter int CLASS2_SLOTS = scbp_pkg::DEF_CLASS2_SLOTS,
    parameter int CLASS3_SLOTS = scbp_pkg::DEF_CLASS3_SLOTS,
    parameter int CLASS4_SLOTS = scbp_pkg::DEF_CLASS4_SLOTS,
    parameter int POOL_BYTES   = scbp_pkg::DEF_POOL_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scbp_pkg::t_dp_cmd                 i_cmd,
    output scbp_pkg::t_dp_sts                 o_sts,
    input  logic                              i_cfg_we,
    input  logic [scbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_func,
    input  logic [scbp_pkg::LEN_W-1:0]        i_request_size,
    input  logic [scbp_pkg::OFS_W-1:0]        i_release_offset,
    output logic [2:0]                        o_status,
    output logic [scbp_pkg::OFS_W-1:0]        o_grant_offset,
    output logic [scbp_pkg::SLOT_IDX_W-1:0]   o_slot_index
);

    localparam int NUM_SLOTS = CLASS1_SLOTS + CLASS2_SLOTS + CLASS3_SLOTS + CLASS4_SLOTS;
    localparam int BOUND1    = CLASS1_SLOTS;
    localparam int BOUND2    = CLASS1_SLOTS + CLASS2_SLOTS;
    localparam int BOUND3    = CLASS1_SLOTS + CLASS2_SLOTS + CLASS3_SLOTS;
    localparam int CNT_W     = (NUM_SLOTS < 1) ? 1 : $clog2(NUM_SLOTS + 1);
    localparam int IDX_W     = (NUM_SLOTS < 2) ? 1 : $clog2(NUM_SLOTS);
    localparam int MAP_W     = (NUM_SLOTS < 1) ? 1 : NUM_SLOTS;
    localparam logic [scbp_pkg::POS_W-1:0] POOL_END = scbp_pkg::POS_W'(POOL_BYTES);
    localparam logic [CNT_W-1:0]           SLOT_CNT = CNT_W'(NUM_SLOTS);

    // Configuration registers
    logic [scbp_pkg::LEN_W-1:0] r_len1, r_len2, r_len3, r_len4;
    logic [scbp_pkg::SPC_W-1:0] r_spc1, r_spc2, r_spc3, r_spc4;

    // Request and walk state
    scbp_pkg::t_func             r_func;
    logic [scbp_pkg::LEN_W-1:0]  r_size;
    logic [scbp_pkg::POS_W-1:0]  r_where;
    logic [scbp_pkg::POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_fit_seen;
    logic [MAP_W-1:0]            r_free_map;
    logic [MAP_W-1:0]            n_free_map;

    // Result registers
    scbp_pkg::t_status                r_status;
    logic [scbp_pkg::OFS_W-1:0]       r_grant_offset;
    logic [scbp_pkg::SLOT_IDX_W-1:0]  r_slot_index;

    logic [IDX_W-1:0]           slot_idx;
    logic                       slot_valid;
    logic                       slot_last;
    logic                       slot_exists;
    logic [scbp_pkg::LEN_W-1:0] slot_len;
    logic [scbp_pkg::SPC_W-1:0] slot_spc;
    logic                       fit_now;
    logic                       fit_any;
    logic                       grant_now;
    logic                       match_now;
    logic                       hit;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= scbp_pkg::RST_CLASS1_LEN;
            r_len2 <= scbp_pkg::RST_CLASS2_LEN;
            r_len3 <= scbp_pkg::RST_CLASS3_LEN;
            r_len4 <= scbp_pkg::RST_CLASS4_LEN;
            r_spc1 <= scbp_pkg::RST_CLASS1_SPC;
            r_spc2 <= scbp_pkg::RST_CLASS2_SPC;
            r_spc3 <= scbp_pkg::RST_CLASS3_SPC;
            r_spc4 <= scbp_pkg::RST_CLASS4_SPC;
        end else if (i_cfg_we) begin
            unique case (scbp_pkg::t_cfg_idx'(i_cfg_index))
                scbp_pkg::CFG_CLASS1_LEN: r_len1 <= i_cfg_data;
                scbp_pkg::CFG_CLASS2_LEN: r_len2 <= i_cfg_data;
                scbp_pkg::CFG_CLASS3_LEN: r_len3 <= i_cfg_data;
                scbp_pkg::CFG_CLASS4_LEN: r_len4 <= i_cfg_data;
                scbp_pkg::CFG_CLASS1_SPC: r_spc1 <= i_cfg_data[scbp_pkg::SPC_W-1:0];
                scbp_pkg::CFG_CLASS2_SPC: r_spc2 <= i_cfg_data[scbp_pkg::SPC_W-1:0];
                scbp_pkg::CFG_CLASS3_SPC: r_spc3 <= i_cfg_data[scbp_pkg::SPC_W-1:0];
                scbp_pkg::CFG_CLASS4_SPC: r_spc4 <= i_cfg_data[scbp_pkg::SPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Class of the current slot from the fixed class boundaries
    always_comb begin
        priority if (int'(r_cnt) < BOUND1) begin
            slot_len = r_len1;
            slot_spc = r_spc1;
        end else if (int'(r_cnt) < BOUND2) begin
            slot_len = r_len2;
            slot_spc = r_spc2;
        end else if (int'(r_cnt) < BOUND3) begin
            slot_len = r_len3;
            slot_spc = r_spc3;
        end else begin
            slot_len = r_len4;
            slot_spc = r_spc4;
        end
    end

    // Per-slot checks
    always_comb begin
        slot_idx    = r_cnt[IDX_W-1:0];
        slot_valid  = (r_cnt < SLOT_CNT);
        slot_last   = (r_cnt == SLOT_CNT - CNT_W'(1));
        slot_exists = slot_valid && (r_pos < POOL_END);
        fit_now     = slot_exists && (r_size <= slot_len);
        fit_any     = r_fit_seen || fit_now;
        grant_now   = slot_exists && fit_any && r_free_map[slot_idx];
        match_now   = slot_exists && (r_pos == r_where);
        hit         = (r_func == scbp_pkg::FUNC_ALLOC) ? grant_now : match_now;
        o_sts.scan_done = hit || !slot_valid || slot_last;
    end

    // Request capture and slot walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= scbp_pkg::t_func'(i_func);
            r_size     <= i_request_size;
            r_where    <= scbp_pkg::POS_W'(i_release_offset);
            r_pos      <= '0;
            r_cnt      <= '0;
            r_fit_seen <= 1'b0;
        end else if (i_cmd.step && slot_valid) begin
            r_pos      <= r_pos + scbp_pkg::POS_W'(slot_spc);
            r_cnt      <= r_cnt + CNT_W'(1);
            r_fit_seen <= fit_any;
        end
    end

    // Free map update on a grant or a matched free
    always_comb begin
        n_free_map = r_free_map;
        if (i_cmd.finish && hit) begin
            n_free_map[slot_idx] = (r_func == scbp_pkg::FUNC_FREE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= '1;
        end else begin
            r_free_map <= n_free_map;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_grant_offset <= '0;
            r_slot_index   <= '0;
            if (r_func == scbp_pkg::FUNC_ALLOC) begin
                priority if (grant_now) begin
                    r_status       <= scbp_pkg::ST_GRANTED;
                    r_grant_offset <= r_pos[scbp_pkg::OFS_W-1:0];
                    r_slot_index   <= scbp_pkg::SLOT_IDX_W'(r_cnt);
                end else if (fit_any) begin
                    r_status <= scbp_pkg::ST_NO_FREE;
                end else begin
                    r_status <= scbp_pkg::ST_NO_CLASS;
                end
            end else begin
                if (match_now) begin
                    r_status     <= scbp_pkg::ST_FREED;
                    r_slot_index <= scbp_pkg::SLOT_IDX_W'(r_cnt);
                end else begin
                    r_status <= scbp_pkg::ST_UNKNOWN;
                end
            end
        end
    end

    assign o_status       = r_status;
    assign o_grant_offset = r_grant_offset;
    assign o_slot_index   = r_slot_index;

endmodule

>>> src/scbp_checker.sv
// ----------------------------------------------------------------------------
// scbp_checker: port-level checks of the buffer pool allocator
// Watches the command/result ports and flags sequencing or result slips.
// ----------------------------------------------------------------------------
module scbp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_result_valid,
    input logic [2:0]                        o_status,
    input logic [scbp_pkg::OFS_W-1:0]        o_grant_offset,
    input logic [scbp_pkg::SLOT_IDX_W-1:0]   o_slot_index
);

    // An accepted request always occupies the walker next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // Result strobe never overlaps the walk
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // No result strobe directly follows another
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held two cycles");

    // Offset only on a grant
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != scbp_pkg::ST_GRANTED)) |-> (o_grant_offset == '0))
        else $error("nonzero offset without grant");

    // No slot index on failures
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == scbp_pkg::ST_NO_CLASS ||
                            o_status == scbp_pkg::ST_NO_FREE ||
                            o_status == scbp_pkg::ST_UNKNOWN)) |-> (o_slot_index == '0))
        else $error("nonzero slot index on failure");

endmodule

bind size_class_buffer_pool_core scbp_checker u_scbp_checker (.*);
